@@ rtl/cksk_pkg.sv @@
package cksk_pkg;

   localparam int unsigned KEY_COUNT = 26;
   localparam int unsigned KEY_W     = 5;

   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'd32;
   localparam logic [7:0] WRAP_SUB = 8'd26;

   // crib words, first character in the high byte
   localparam logic [39:0] CRIB_THE = 40'h20_54_48_45_20;
   localparam logic [39:0] CRIB_AND = 40'h20_41_4E_44_20;
   localparam logic [31:0] CRIB_BE  = 32'h20_42_45_20;
   localparam logic [31:0] CRIB_TO  = 32'h20_54_4F_20;
   localparam logic [31:0] CRIB_OF  = 32'h20_4F_46_20;

   typedef enum logic [0:0] {
      FUNC_LOAD = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef struct packed {
      logic       func;
      logic [7:0] char_in;
      logic       last_char;
      logic [9:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] best_key;
      logic [7:0]       decoded_char;
      logic [10:0]      msg_length;
      logic             overflow;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_RDWAIT = 5'b00100,
      ST_CHOOSE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_exec;
      logic read_exec;
      logic read_latch;
      logic choose;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_last;
   } status_type;

   function automatic logic [7:0] rot_decode(input logic [7:0] ch, input logic [KEY_W-1:0] key);
      logic [7:0] sum;
      sum = ch + {3'b000, key};
      if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
         if (sum > CH_UP_Z) begin
            return sum - WRAP_SUB;
         end
         return sum;
      end
      return ch;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] ch);
      if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
         return ch - CASE_GAP;
      end
      return ch;
   endfunction

   // raw holds five characters, oldest in the high byte
   function automatic logic lane_hit(input logic [39:0] raw, input logic [KEY_W-1:0] key);
      logic [39:0] dec;
      for (int i = 0; i < 5; i++) begin
         dec[i*8 +: 8] = rot_decode(raw[i*8 +: 8], key);
      end
      return (dec == CRIB_THE) || (dec == CRIB_AND) || (dec[31:0] == CRIB_BE)
          || (dec[31:0] == CRIB_TO) || (dec[31:0] == CRIB_OF);
   endfunction

endpackage

@@ rtl/cksk_intf.sv @@
interface cksk_req_if import cksk_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cksk_rsp_if import cksk_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/caesar_key_search_by_keywords.sv @@
// Rotation-key search over a message by crib words.
// req_bus takes one word per item: func = load stores one character (a-z folded
// to upper case) and tests all 26 key lanes against " THE ", " AND ", " BE ",
// " TO " and " OF " ending at that character; func = read returns the stored
// character at read_index, decoded with the chosen key.
// rsp_bus gives one word per read and one summary word per load with last_char
// set: found, highest hitting key, decoded character, length, overflow flag.
// Loads past MSG_DEPTH characters are dropped and set overflow.
// State sequence after an accepting edge:
//   load, not last : EXEC, then back to IDLE for the next accept; no response
//   load, last     : EXEC, CHOOSE (key pick stage), then RESP with the
//                    response valid until taken, then IDLE
//   read           : EXEC, RDWAIT (store read), then RESP with the response
//                    valid until taken, then IDLE
// One word is in flight at a time; ready is low from accept until the block is
// idle, after any response is taken; a stalled receiver just holds the response.
// Reset is synchronous; the message store needs no clearing and the block
// is ready the cycle after reset drops. The next load after a summary
// starts a new message.
module caesar_key_search_by_keywords import cksk_pkg::*; #(
   parameter int MSG_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   cksk_req_if.sink          req_bus,
   cksk_rsp_if.source        rsp_bus
);

   cmd_type    cmd;
   status_type status;

   cksk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cksk_datapath #(
      .MSG_DEPTH (MSG_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_bus.payload),
      .rsp_word (rsp_bus.payload)
   );

endmodule

@@ rtl/cksk_ram.sv @@
module cksk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cksk_ctrl.sv @@
module cksk_ctrl import cksk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_read) begin
               cmd.read_exec = 1'b1;
               state_in      = ST_RDWAIT;
            end else begin
               cmd.load_exec = 1'b1;
               state_in      = status.is_last ? ST_CHOOSE : ST_IDLE;
            end
         end
         ST_RDWAIT: begin
            cmd.read_latch = 1'b1;
            state_in       = ST_RESP;
         end
         ST_CHOOSE: begin
            cmd.choose = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

@@ rtl/cksk_datapath.sv @@
module cksk_datapath import cksk_pkg::*; #(
   parameter int MSG_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(MSG_DEPTH);
   localparam int CW = $clog2(MSG_DEPTH + 1);
   localparam logic [CW-1:0]   DEPTH_C   = CW'(MSG_DEPTH);
   localparam logic [CW+9:0]   DEPTH_EXT = (CW + 10)'(MSG_DEPTH);

   req_word_type           word_ff;
   logic [31:0]            window_ff, window_in;
   logic [KEY_COUNT-1:0]   hit_ff, hit_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [KEY_W-1:0]       chosen_ff, chosen_in;
   logic                   keyv_ff, keyv_in;
   logic                   drop_ff, drop_in;
   logic                   start_ff, start_in;
   logic                   inrange_ff, inrange_in;
   rsp_word_type           rsp_ff, rsp_in;

   // message state as seen by a load, after the new-message clear
   logic [31:0]            eff_window;
   logic [KEY_COUNT-1:0]   eff_hit;
   logic [CW-1:0]          eff_count;
   logic                   eff_drop;
   logic [7:0]             ch_fold;
   logic                   full;
   logic [KEY_COUNT-1:0]   lane_hits;

   logic [KEY_W-1:0]       high_key;
   logic [CW+10:0]         len_ext;
   logic [CW+9:0]          idx_ext;
   logic [CW+9:0]          cnt_ext;
   logic [AW+9:0]          addr_ext;
   logic [7:0]             rd_data;
   logic                   wr_en;
   logic [7:0]             read_val;

   assign status.is_read = (word_ff.func == FUNC_READ);
   assign status.is_last = word_ff.last_char;

   assign eff_window = start_ff ? '0 : window_ff;
   assign eff_hit    = start_ff ? '0 : hit_ff;
   assign eff_count  = start_ff ? '0 : count_ff;
   assign eff_drop   = start_ff ? 1'b0 : drop_ff;
   assign ch_fold    = fold_case(word_ff.char_in);
   assign full       = (eff_count == DEPTH_C);

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
      assign lane_hits[k] = lane_hit({eff_window, ch_fold}, KEY_W'(k));
   end

   always_comb begin
      high_key = chosen_ff;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (hit_ff[k]) begin
            high_key = KEY_W'(k);
         end
      end
   end

   assign len_ext  = {11'b0, count_ff};
   assign idx_ext  = {{CW{1'b0}}, word_ff.read_index};
   assign cnt_ext  = {10'b0, count_ff};
   assign addr_ext = {{AW{1'b0}}, word_ff.read_index};
   assign wr_en    = cmd.load_exec && !full;

   cksk_ram #(
      .WIDTH (8),
      .DEPTH (MSG_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eff_count[AW-1:0]),
      .wr_data (ch_fold),
      .rd_addr (addr_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      read_val = 8'd0;
      if (inrange_ff) begin
         read_val = keyv_ff ? rot_decode(rd_data, chosen_ff) : rd_data;
      end
   end

   always_comb begin
      window_in  = window_ff;
      hit_in     = hit_ff;
      count_in   = count_ff;
      chosen_in  = chosen_ff;
      keyv_in    = keyv_ff;
      drop_in    = drop_ff;
      start_in   = start_ff;
      inrange_in = inrange_ff;
      rsp_in     = rsp_ff;

      if (cmd.load_exec) begin
         chosen_in = start_ff ? '0 : chosen_ff;
         keyv_in   = start_ff ? 1'b0 : keyv_ff;
         start_in  = 1'b0;
         if (full) begin
            window_in = eff_window;
            hit_in    = eff_hit;
            count_in  = eff_count;
            drop_in   = 1'b1;
         end else begin
            window_in = {eff_window[23:0], ch_fold};
            hit_in    = eff_hit | lane_hits;
            count_in  = CW'(eff_count + 1'b1);
            drop_in   = eff_drop;
         end
      end

      if (cmd.read_exec) begin
         inrange_in = (idx_ext < cnt_ext) && (idx_ext < DEPTH_EXT);
      end

      if (cmd.read_latch) begin
         rsp_in.found        = keyv_ff;
         rsp_in.best_key     = chosen_ff;
         rsp_in.decoded_char = read_val;
         rsp_in.msg_length   = len_ext[10:0];
         rsp_in.overflow     = drop_ff;
      end

      if (cmd.choose) begin
         chosen_in           = high_key;
         keyv_in             = keyv_ff | (|hit_ff);
         start_in            = 1'b1;
         rsp_in.found        = keyv_ff | (|hit_ff);
         rsp_in.best_key     = high_key;
         rsp_in.decoded_char = 8'd0;
         rsp_in.msg_length   = len_ext[10:0];
         rsp_in.overflow     = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         hit_ff    <= '0;
         count_ff  <= '0;
         chosen_ff <= '0;
         keyv_ff   <= 1'b0;
         drop_ff   <= 1'b0;
         start_ff  <= 1'b1;
      end else begin
         window_ff <= window_in;
         hit_ff    <= hit_in;
         count_ff  <= count_in;
         chosen_ff <= chosen_in;
         keyv_ff   <= keyv_in;
         drop_ff   <= drop_in;
         start_ff  <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff <= req_word;
      end
      inrange_ff <= inrange_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule
